>>> rtl/scpg_pkg.sv
// ----------------------------------------------------------------------------
// scpg_pkg
// Shared types, constants and small arithmetic helpers for the shaded
// checkerboard pixel generator.
// ----------------------------------------------------------------------------
package scpg_pkg;

	localparam int REG_W   = 13;
	localparam int SIDE_W  = 10;
	localparam int FRAC_W  = 16;
	localparam int SQ_W    = 32;
	localparam int ROOT_W  = 16;
	localparam int SREM_W  = 19;
	localparam int INDEX_W = 2;

	localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [SIDE_W-1:0] MIN_SIDE   = 10'd4;
	localparam logic [FRAC_W-1:0] HALF_Q16   = 16'h8000;
	localparam logic [16:0]       ONE_Q16    = 17'h10000;
	localparam logic [14:0]       K_POINT4   = 15'd26214;
	localparam logic [7:0]        GREY_BASE  = 8'd200;
	localparam logic [5:0]        GREY_SPAN  = 6'd55;
	localparam logic [7:0]        DARK_BASE  = 8'd40;
	localparam logic [5:0]        DARK_SPAN  = 6'd60;
	localparam logic [7:0]        RECIP_5_10 = 8'd205;

	typedef struct packed {
		logic line_end;
		logic frame_end;
	} tag_t;

	// floor(v / 5) for v below 512
	function automatic logic [7:0] div5(input logic [8:0] v);
		logic [17:0] p;
		p = 18'(v) * 18'(RECIP_5_10);
		return 8'(p >> 10);
	endfunction

	// floor(v / 10) for v below 1024
	function automatic logic [7:0] div10(input logic [9:0] v);
		logic [17:0] p;
		p = 18'(v) * 18'(RECIP_5_10);
		return 8'(p >> 11);
	endfunction

endpackage

>>> rtl/scpg_div_cell.sv
// ----------------------------------------------------------------------------
// scpg_div_cell
// One restoring division step for the x and y lanes. The word shifts the
// dividend out at the top and the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module scpg_div_cell
	import scpg_pkg::*;
#(
	parameter int W = 28
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [SIDE_W-1:0] side,
	input  logic              in_valid,
	input  tag_t              in_tag,
	input  logic [W-1:0]      in_xw,
	input  logic [SIDE_W-1:0] in_xr,
	input  logic [W-1:0]      in_yw,
	input  logic [SIDE_W-1:0] in_yr,
	output logic              out_valid,
	output tag_t              out_tag,
	output logic [W-1:0]      out_xw,
	output logic [SIDE_W-1:0] out_xr,
	output logic [W-1:0]      out_yw,
	output logic [SIDE_W-1:0] out_yr
);

	logic              valid_q;
	tag_t              tag_q;
	logic [W-1:0]      xw_q, yw_q;
	logic [SIDE_W-1:0] xr_q, yr_q;
	logic [SIDE_W:0]   xt, yt, xd, yd, sd;
	logic              xge, yge;

	always_comb begin
		sd  = {1'b0, side};
		xt  = {in_xr, in_xw[W-1]};
		yt  = {in_yr, in_yw[W-1]};
		xge = xt >= sd;
		yge = yt >= sd;
		xd  = xge ? xt - sd : xt;
		yd  = yge ? yt - sd : yt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= in_tag;
			xr_q  <= xd[SIDE_W-1:0];
			yr_q  <= yd[SIDE_W-1:0];
			xw_q  <= {in_xw[W-2:0], xge};
			yw_q  <= {in_yw[W-2:0], yge};
		end
	end

	assign out_valid = valid_q;
	assign out_tag   = tag_q;
	assign out_xw    = xw_q;
	assign out_xr    = xr_q;
	assign out_yw    = yw_q;
	assign out_yr    = yr_q;

endmodule

>>> rtl/scpg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// scpg_sqrt_cell
// One digit step of the integer square root: brings down two radicand bits
// and settles one root bit.
// ----------------------------------------------------------------------------
module scpg_sqrt_cell
	import scpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  tag_t              in_tag,
	input  logic              in_light,
	input  logic [SQ_W-1:0]   in_rad,
	input  logic [SREM_W-1:0] in_rem,
	input  logic [ROOT_W-1:0] in_root,
	output logic              out_valid,
	output tag_t              out_tag,
	output logic              out_light,
	output logic [SQ_W-1:0]   out_rad,
	output logic [SREM_W-1:0] out_rem,
	output logic [ROOT_W-1:0] out_root
);

	logic              valid_q;
	tag_t              tag_q;
	logic              light_q;
	logic [SQ_W-1:0]   rad_q;
	logic [SREM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W-1:0] cur, trial;
	logic              ge;

	always_comb begin
		cur   = {in_rem[SREM_W-3:0], in_rad[SQ_W-1 -: 2]};
		trial = SREM_W'({in_root, 2'b01});
		ge    = cur >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q   <= in_tag;
			light_q <= in_light;
			rad_q   <= {in_rad[SQ_W-3:0], 2'b00};
			rem_q   <= ge ? cur - trial : cur;
			root_q  <= {in_root[ROOT_W-2:0], ge};
		end
	end

	assign out_valid = valid_q;
	assign out_tag   = tag_q;
	assign out_light = light_q;
	assign out_rad   = rad_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;

endmodule

>>> rtl/shaded_checkerboard_pixel_gen_core.sv
// ----------------------------------------------------------------------------
// shaded_checkerboard_pixel_gen_core
// Shaded checkerboard test pattern: coordinate in, RGB plus line/frame end out.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | in_valid / in_ready  | pix_x, pix_y
// out      | out_valid / out_ready| red, green, blue, line_end, frame_end
// cfg      | cfg_we               | cfg_index, cfg_data
//
// Pipeline: COORD_BITS+16 divider cells, three distance stages, 16 root
// cells and two shading stages; one transaction per cycle unless a stalled
// output holds the whole pipeline; in_ready follows that stall.
// Reset clears the stage valids and loads width and height of 256.
// ----------------------------------------------------------------------------
module shaded_checkerboard_pixel_gen_core
	import scpg_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] pix_x,
	input  logic [COORD_BITS-1:0] pix_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	output logic                  line_end,
	output logic                  frame_end,
	input  logic                  cfg_we,
	input  logic [INDEX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]      cfg_data
);

	localparam int DIV_W = COORD_BITS + FRAC_W;

	logic [REG_W-1:0]  width_q, height_q;
	logic [SIDE_W-1:0] side;
	logic              en;
	tag_t              in_tag;
	logic [16:0]       x_ext, y_ext, w_m1, h_m1;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd256;
			height_q <= 13'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		side  = (width_q[REG_W-1:3] < MIN_SIDE) ? MIN_SIDE : width_q[REG_W-1:3];
		x_ext = 17'(pix_x);
		y_ext = 17'(pix_y);
		w_m1  = 17'(width_q) - 17'd1;
		h_m1  = 17'(height_q) - 17'd1;
		in_tag.line_end  = (width_q != '0) && (x_ext == w_m1);
		in_tag.frame_end = in_tag.line_end && (height_q != '0) && (y_ext == h_m1);
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// divider chain: quotient of (coord << 16) / side
	logic              dv [0:DIV_W];
	tag_t              dt [0:DIV_W];
	logic [DIV_W-1:0]  dxw [0:DIV_W];
	logic [DIV_W-1:0]  dyw [0:DIV_W];
	logic [SIDE_W-1:0] dxr [0:DIV_W];
	logic [SIDE_W-1:0] dyr [0:DIV_W];

	assign dv[0]  = in_valid;
	assign dt[0]  = in_tag;
	assign dxw[0] = {pix_x, {FRAC_W{1'b0}}};
	assign dyw[0] = {pix_y, {FRAC_W{1'b0}}};
	assign dxr[0] = '0;
	assign dyr[0] = '0;

	for (genvar i = 0; i < DIV_W; i++) begin : g_div
		scpg_div_cell #(.W(DIV_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .side(side),
			.in_valid(dv[i]), .in_tag(dt[i]),
			.in_xw(dxw[i]), .in_xr(dxr[i]), .in_yw(dyw[i]), .in_yr(dyr[i]),
			.out_valid(dv[i+1]), .out_tag(dt[i+1]),
			.out_xw(dxw[i+1]), .out_xr(dxr[i+1]), .out_yw(dyw[i+1]), .out_yr(dyr[i+1])
		);
	end

	// centre offsets, squares, sum
	logic [FRAC_W-1:0] nx, ny;
	logic              v_s1, v_s2, v_s3;
	tag_t              t_s1, t_s2, t_s3;
	logic              l_s1, l_s2, l_s3;
	logic [FRAC_W-1:0] ax_s1, ay_s1;
	logic [SQ_W-1:0]   xx_s2, yy_s2, sq_s3;

	assign nx = dxw[DIV_W][FRAC_W-1:0];
	assign ny = dyw[DIV_W][FRAC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= dv[DIV_W];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= dt[DIV_W];
			l_s1  <= !(dxw[DIV_W][FRAC_W] ^ dyw[DIV_W][FRAC_W]);
			ax_s1 <= (nx >= HALF_Q16) ? nx - HALF_Q16 : HALF_Q16 - nx;
			ay_s1 <= (ny >= HALF_Q16) ? ny - HALF_Q16 : HALF_Q16 - ny;
			t_s2  <= t_s1;
			l_s2  <= l_s1;
			xx_s2 <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			yy_s2 <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			t_s3  <= t_s2;
			l_s3  <= l_s2;
			sq_s3 <= xx_s2 + yy_s2;
		end
	end

	// root chain
	logic              rv [0:ROOT_W];
	tag_t              rt [0:ROOT_W];
	logic              rl [0:ROOT_W];
	logic [SQ_W-1:0]   rrad [0:ROOT_W];
	logic [SREM_W-1:0] rrem [0:ROOT_W];
	logic [ROOT_W-1:0] rroot [0:ROOT_W];

	assign rv[0]    = v_s3;
	assign rt[0]    = t_s3;
	assign rl[0]    = l_s3;
	assign rrad[0]  = sq_s3;
	assign rrem[0]  = '0;
	assign rroot[0] = '0;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		scpg_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(rv[j]), .in_tag(rt[j]), .in_light(rl[j]),
			.in_rad(rrad[j]), .in_rem(rrem[j]), .in_root(rroot[j]),
			.out_valid(rv[j+1]), .out_tag(rt[j+1]), .out_light(rl[j+1]),
			.out_rad(rrad[j+1]), .out_rem(rrem[j+1]), .out_root(rroot[j+1])
		);
	end

	// shading
	logic              v_s4, v_s5;
	tag_t              t_s4, t_s5;
	logic              l_s4, l_s5;
	logic [14:0]       prod_s4;
	logic [5:0]        dm_s4;
	logic [30:0]       prod_full;
	logic [21:0]       dm_full;
	logic [22:0]       grey_full;
	logic [16:0]       grd;
	logic [7:0]        grey, base;
	logic [7:0]        r_s5, g_s5, b_s5;

	assign prod_full = 31'(rroot[ROOT_W]) * 31'(K_POINT4);
	assign dm_full   = 22'(rroot[ROOT_W]) * 22'(DARK_SPAN);

	always_comb begin
		grd       = ONE_Q16 - 17'(prod_s4);
		grey_full = 23'(grd) * 23'(GREY_SPAN);
		grey      = GREY_BASE + 8'(grey_full >> 16);
		base      = DARK_BASE + 8'(dm_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= rv[ROOT_W];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4    <= rt[ROOT_W];
			l_s4    <= rl[ROOT_W];
			prod_s4 <= prod_full[30:16];
			dm_s4   <= dm_full[21:16];
			t_s5    <= t_s4;
			l_s5    <= l_s4;
			r_s5    <= l_s4 ? grey : div5(9'({base, 2'b00}));
			g_s5    <= l_s4 ? grey : div10(10'(base) * 10'd9);
			b_s5    <= l_s4 ? grey : base;
		end
	end

	assign out_valid = v_s5;
	assign red       = r_s5;
	assign green     = g_s5;
	assign blue      = b_s5;
	assign line_end  = t_s5.line_end;
	assign frame_end = t_s5.frame_end;

	a_light_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && l_s5 |-> red == green && green == blue && red >= GREY_BASE)
		else $error("light square not grey");
	a_dark_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !l_s5 |-> red <= green && green <= blue)
		else $error("dark square channel order");
	a_frame_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> line_end)
		else $error("frame end without line end");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(r_s5) && $stable(t_s5))
		else $error("stalled result changed");

endmodule
